// ----- hw/rtl/tsf_pkg.sv -----
// Shared constants and types for the transport stream PID filter.
package tsf_pkg;

    localparam int unsigned PID_W          = 13;
    localparam int unsigned PACKET_LEN     = 188;
    localparam logic [7:0]  SYNC_BYTE      = 8'h47;
    localparam logic [12:0] NULL_PID       = 13'h1FFF;
    localparam logic [7:0]  MAX_ADAPT_LEN  = 8'd183;
    localparam int unsigned DEF_SLOTS      = 4;
    localparam int unsigned DEF_COUNT_W    = 32;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 13;
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PMT_PID  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_D = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_EN  = 3'd5;

    localparam logic [1:0] ROUTE_PAT    = 2'd0;
    localparam logic [1:0] ROUTE_PMT    = 2'd1;
    localparam logic [1:0] ROUTE_STREAM = 2'd2;

    localparam logic [1:0] AFC_PAYLOAD = 2'd1;
    localparam logic [1:0] AFC_BOTH    = 2'd3;

    // Classified word handed from the front end to the back end
    typedef struct packed {
        logic [7:0]       data;
        logic [PID_W-1:0] pid;
        logic [1:0]       route;
        logic [1:0]       slot;
        logic             first;
        logic             last;
        logic             unit_start;
        logic             random_access;
        logic             discontinuity;
        logic             cc_bad;
        logic [31:0]      skipped;
        logic [31:0]      cc_errors;
    } tsf_word_t;

    // Input channel word
    typedef struct packed {
        logic [7:0] stream_byte;
    } tsf_in_t;

    // Output channel word
    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [PID_W-1:0] packet_pid;
        logic [1:0]       route;
        logic [1:0]       slot_index;
        logic             first_of_packet;
        logic             last_of_packet;
        logic             unit_start;
        logic             random_access;
        logic             discontinuity;
        logic             cc_mismatch;
        logic [31:0]      skipped_bytes;
        logic [31:0]      continuity_errors;
    } tsf_out_t;

endpackage

// ----- hw/rtl/tsf_if.sv -----
// Valid/ready channel interface carrying one payload word.
interface tsf_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/tsf_front.sv -----
// Front end: sync hunt, header parse, packet verdict and continuity check.
module tsf_front #(
    parameter int unsigned STREAM_SLOTS = tsf_pkg::DEF_SLOTS,
    parameter int unsigned COUNT_WIDTH  = tsf_pkg::DEF_COUNT_W
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                      byte_valid,
    input  logic [7:0]                byte_in,
    output logic                      word_valid,
    output tsf_pkg::tsf_word_t        word
);
    import tsf_pkg::*;

    logic [12:0] pmt_pid_reg;
    logic [12:0] stream_pid_reg [4];
    logic [3:0]  slot_enable_reg;
    logic [3:0]  last_cc_reg [4];
    logic [3:0]  seen_reg;

    logic [7:0]  pos_reg;
    logic [23:0] hdr_reg;
    logic [7:0]  alen_reg;
    logic [1:0]  aflags_reg;
    logic        keep_reg;
    logic [1:0]  route_reg;
    logic [1:0]  slot_reg;
    logic        bad_reg;
    logic [COUNT_WIDTH-1:0] skip_reg;
    logic [COUNT_WIDTH-1:0] mism_reg;

    logic [12:0] hpid;
    logic [1:0]  afc;
    logic [3:0]  cc;
    logic        keep_next;
    logic [1:0]  route_next;
    logic [1:0]  slot_next;
    logic        bad_next;
    logic        hit;
    logic [7:0]  alen_cur;
    logic [1:0]  aflags_cur;
    logic        keep_cur;
    logic [8:0]  start;
    logic        in_body;
    logic        skip_inc;
    logic        mismatch_inc;
    logic [COUNT_WIDTH-1:0] skip_next;
    logic [COUNT_WIDTH-1:0] mism_next;

    function automatic logic [31:0] cap32(input logic [COUNT_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    assign hpid = hdr_reg[20:8];
    assign afc  = hdr_reg[5:4];
    assign cc   = hdr_reg[3:0];

    always_comb
    begin
        keep_next  = 1'b0;
        route_next = ROUTE_PAT;
        slot_next  = 2'd0;
        bad_next   = 1'b0;
        hit        = 1'b0;
        if (!(hdr_reg[23] || hpid == NULL_PID || !afc[0]
              || (afc == AFC_BOTH && byte_in >= MAX_ADAPT_LEN)))
        begin
            if (hpid == 13'd0)
            begin
                keep_next = 1'b1;
            end
            else if (hpid == pmt_pid_reg && pmt_pid_reg != NULL_PID)
            begin
                keep_next  = 1'b1;
                route_next = ROUTE_PMT;
            end
            else
            begin
                for (int s = STREAM_SLOTS - 1; s >= 0; s--)
                begin
                    if (slot_enable_reg[s] && stream_pid_reg[s] == hpid)
                    begin
                        hit       = 1'b1;
                        slot_next = 2'(s);
                    end
                end
                if (hit)
                begin
                    keep_next  = 1'b1;
                    route_next = ROUTE_STREAM;
                    bad_next   = seen_reg[slot_next] && cc != last_cc_reg[slot_next] + 4'd1;
                end
            end
        end
    end

    assign in_body    = byte_valid && pos_reg >= 8'd4;
    assign alen_cur   = (pos_reg == 8'd4) ? byte_in : alen_reg;
    assign keep_cur   = (pos_reg == 8'd4) ? keep_next : keep_reg;
    assign start      = (afc == AFC_BOTH) ? 9'd5 + {1'b0, alen_cur} : 9'd4;
    assign aflags_cur = (pos_reg == 8'd5 && afc == AFC_BOTH && alen_reg != 8'd0)
                        ? {byte_in[7], byte_in[6]} : ((pos_reg == 8'd4) ? 2'b00 : aflags_reg);

    assign skip_inc     = byte_valid && pos_reg == 8'd0 && byte_in != SYNC_BYTE;
    assign mismatch_inc = byte_valid && pos_reg == 8'd4 && bad_next;
    assign word_valid   = in_body && keep_cur && {1'b0, pos_reg} >= start;

    // Saturating counts; the word carries them including this byte's own event
    assign skip_next = (skip_inc && skip_reg != '1) ? skip_reg + 1'b1 : skip_reg;
    assign mism_next = (mismatch_inc && mism_reg != '1) ? mism_reg + 1'b1 : mism_reg;

    always_comb
    begin
        word.data          = byte_in;
        word.pid           = hpid;
        word.route         = (pos_reg == 8'd4) ? route_next : route_reg;
        word.slot          = (pos_reg == 8'd4) ? slot_next : slot_reg;
        word.first         = {1'b0, pos_reg} == start;
        word.last          = pos_reg == 8'(PACKET_LEN - 1);
        word.unit_start    = hdr_reg[22];
        word.random_access = aflags_cur[0];
        word.discontinuity = aflags_cur[1];
        word.cc_bad        = (pos_reg == 8'd4) ? bad_next : bad_reg;
        word.skipped       = cap32(skip_next);
        word.cc_errors     = cap32(mism_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= 8'd0;
            hdr_reg         <= 24'd0;
            alen_reg        <= 8'd0;
            aflags_reg      <= 2'b00;
            keep_reg        <= 1'b0;
            route_reg       <= ROUTE_PAT;
            slot_reg        <= 2'd0;
            bad_reg         <= 1'b0;
            skip_reg        <= '0;
            mism_reg        <= '0;
            pmt_pid_reg     <= NULL_PID;
            slot_enable_reg <= 4'd0;
            seen_reg        <= 4'd0;
            for (int s = 0; s < 4; s++)
            begin
                stream_pid_reg[s] <= NULL_PID;
                last_cc_reg[s]    <= 4'd0;
            end
        end
        else
        begin
            skip_reg <= skip_next;
            mism_reg <= mism_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_PMT_PID)
                begin
                    pmt_pid_reg <= cfg_data;
                end
                else if (cfg_index >= REG_STREAM_A && cfg_index <= REG_STREAM_D)
                begin
                    stream_pid_reg[2'(cfg_index - REG_STREAM_A)] <= cfg_data;
                    seen_reg[2'(cfg_index - REG_STREAM_A)]       <= 1'b0;
                    last_cc_reg[2'(cfg_index - REG_STREAM_A)]    <= 4'd0;
                end
                else if (cfg_index == REG_SLOT_EN)
                begin
                    slot_enable_reg <= cfg_data[3:0];
                end
            end
            if (byte_valid)
            begin
                if (pos_reg == 8'd0)
                begin
                    if (byte_in == SYNC_BYTE)
                    begin
                        pos_reg <= 8'd1;
                    end
                end
                else if (pos_reg < 8'd4)
                begin
                    hdr_reg <= {hdr_reg[15:0], byte_in};
                    pos_reg <= pos_reg + 8'd1;
                end
                else
                begin
                    pos_reg    <= (pos_reg == 8'(PACKET_LEN - 1)) ? 8'd0 : pos_reg + 8'd1;
                    alen_reg   <= alen_cur;
                    aflags_reg <= aflags_cur;
                    if (pos_reg == 8'd4)
                    begin
                        keep_reg  <= keep_next;
                        route_reg <= route_next;
                        slot_reg  <= slot_next;
                        bad_reg   <= bad_next;
                        if (hit && keep_next)
                        begin
                            last_cc_reg[slot_next] <= cc;
                            seen_reg[slot_next]    <= 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- hw/rtl/tsf_queue.sv -----
// Short word queue between front end and back end.
module tsf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tsf_pkg::tsf_word_t push_word,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output tsf_pkg::tsf_word_t head
);
    import tsf_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    tsf_word_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full  = cnt_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
        end
    end

endmodule

// ----- hw/rtl/tsf_back.sv -----
// Back end: the registered output word.
module tsf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_valid,
    input  tsf_pkg::tsf_word_t word,
    output logic               word_ready,
    tsf_if.source              out
);
    import tsf_pkg::*;

    logic ovalid_reg;

    assign word_ready = !ovalid_reg || out.ready;
    assign out.valid  = ovalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (word_ready)
            begin
                ovalid_reg <= word_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_ready && word_valid)
        begin
            out.payload.payload_byte      <= word.data;
            out.payload.packet_pid        <= word.pid;
            out.payload.route             <= word.route;
            out.payload.slot_index        <= (word.route == ROUTE_STREAM) ? word.slot : 2'd0;
            out.payload.first_of_packet   <= word.first;
            out.payload.last_of_packet    <= word.last;
            out.payload.unit_start        <= word.unit_start;
            out.payload.random_access     <= word.random_access;
            out.payload.discontinuity     <= word.discontinuity;
            out.payload.cc_mismatch       <= word.route == ROUTE_STREAM && word.cc_bad;
            out.payload.skipped_bytes     <= word.skipped;
            out.payload.continuity_errors <= word.cc_errors;
        end
    end

endmodule

// ----- hw/rtl/ts_packet_sync_pid_filter.sv -----
// Top level of the transport stream sync and PID filter.
//
//   channel  | dir | payload
//   in       | in  | stream_byte
//   out      | out | payload_byte .. continuity_errors
//   cfg      | in  | cfg_we, cfg_index, cfg_data
//
// One byte a cycle while the queue has room; the front end classifies each byte
// in the cycle it is taken. A result passes through the four-word queue and then
// the output register before it reaches out.valid.
// Input stalls whenever the queue is full.
// Reset clears framing, counters and registers to their defaults.
module ts_packet_sync_pid_filter #(
    parameter int unsigned STREAM_SLOTS = tsf_pkg::DEF_SLOTS,
    parameter int unsigned COUNT_WIDTH  = tsf_pkg::DEF_COUNT_W
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0] cfg_data,
    tsf_if.sink                            in,
    tsf_if.source                          out
);
    import tsf_pkg::*;

    logic      fvalid;
    tsf_word_t fword;
    logic      q_full;
    logic      q_empty;
    tsf_word_t q_head;
    logic      b_ready;
    logic      take;

    // Hold input while the queue is full
    assign in.ready = !q_full;
    assign take     = in.valid && !q_full;

    tsf_front #(.STREAM_SLOTS(STREAM_SLOTS), .COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .byte_valid(take), .byte_in(in.payload.stream_byte),
        .word_valid(fvalid), .word(fword)
    );

    tsf_queue u_queue (
        .clk, .rst_n,
        .push(fvalid), .push_word(fword), .full(q_full),
        .pop(!q_empty && b_ready), .empty(q_empty), .head(q_head)
    );

    tsf_back u_back (
        .clk, .rst_n,
        .word_valid(!q_empty), .word(q_head), .word_ready(b_ready),
        .out
    );

endmodule
